// ===== hdl/ipv6_prefix_acl_match_assert.svh =====
// assertion macros for the prefix access list
`ifndef IPV6_PREFIX_ACL_MATCH_ASSERT_SVH
`define IPV6_PREFIX_ACL_MATCH_ASSERT_SVH

// checked outside reset only
`define ACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define ACL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/ipacl_pkg.sv =====
`default_nettype none

package ipacl_pkg;

  localparam int unsigned DEF_ENTRIES = 16;
  localparam int unsigned IN_W        = 272;
  localparam int unsigned USER_W      = 2;
  localparam int unsigned OUT_W       = 8;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_TEST  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic exec_add;
    logic exec_clear;
    logic rd_first;
    logic rd_next;
    logic hit;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  empty;
    logic  match;
    logic  last;
    logic  out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/ipacl_ram.sv =====
`default_nettype none

module ipacl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/ipacl_dp.sv =====
`default_nettype none

module ipacl_dp #(
  parameter int unsigned ENTRIES = ipacl_pkg::DEF_ENTRIES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ipacl_pkg::IN_W-1:0]   in_data_i,
  input  wire logic [ipacl_pkg::USER_W-1:0] in_user_i,
  input  wire ipacl_pkg::cmd_t              cmd_i,
  output ipacl_pkg::sts_t                   sts_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [ipacl_pkg::OUT_W-1:0]       out_data_o
);
  import ipacl_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        deny;
    logic [7:0]  scope;
  } entry_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic        negate;
    logic [7:0]  scope;
  } item_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  item_t            item_d, item_q;
  logic [CNT_W-1:0] count_d, count_q;
  logic [IDX_W-1:0] idx_d, idx_q;
  logic             permit_d, permit_q;
  logic             err_d, err_q;
  logic             out_valid_d, out_valid_q;
  logic [OUT_W-1:0] out_data_d, out_data_q;

  entry_t           wr_entry, rd_entry;
  logic [ENTRY_W-1:0] rd_word;
  logic [IDX_W-1:0] raddr;
  logic             full;
  logic             ram_we;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W+4:0] cnt_ext;

  assign full    = (count_q == CNT_W'(ENTRIES));
  assign ram_we  = cmd_i.exec_add && !full;
  assign raddr   = cmd_i.rd_first ? '0 : idx_q + IDX_W'(1);
  assign idx_ext = CNT_W'(idx_q);
  assign cnt_ext = {5'b0, count_q};

  assign wr_entry = '{addr_hi: item_q.addr_hi, addr_lo: item_q.addr_lo,
                      mask_hi: item_q.mask_hi, mask_lo: item_q.mask_lo,
                      deny: item_q.negate, scope: item_q.scope};
  assign rd_entry = entry_t'(rd_word);

  ipacl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[IDX_W-1:0]),
    .wdata_i (wr_entry),
    .raddr_i (raddr),
    .rdata_o (rd_word)
  );

  // unpack the incoming item
  always_comb begin
    item_d = item_q;
    if (cmd_i.load) begin
      item_d.kind    = kind_e'(in_user_i);
      item_d.addr_hi = in_data_i[63:0];
      item_d.addr_lo = in_data_i[127:64];
      item_d.mask_hi = in_data_i[191:128];
      item_d.mask_lo = in_data_i[255:192];
      item_d.negate  = in_data_i[256];
      item_d.scope   = in_data_i[264:257];
    end
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    permit_d    = permit_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (cmd_i.load) begin
      permit_d = 1'b0;
      err_d    = 1'b0;
    end
    if (cmd_i.exec_add) begin
      if (full) begin
        err_d = 1'b1;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.exec_clear) begin
      count_d = '0;
    end
    if (cmd_i.rd_first) begin
      idx_d = '0;
    end
    if (cmd_i.rd_next) begin
      idx_d = idx_q + IDX_W'(1);
    end
    if (cmd_i.hit) begin
      permit_d = ~rd_entry.deny;
    end
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      out_data_d  = {1'b0, err_q, cnt_ext[4:0], permit_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    idx_q      <= idx_d;
    permit_q   <= permit_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
  end

  assign sts_o.kind     = item_q.kind;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.match    = ((item_q.addr_hi & rd_entry.mask_hi) == rd_entry.addr_hi)
                       && ((item_q.addr_lo & rd_entry.mask_lo) == rd_entry.addr_lo)
                       && ((rd_entry.scope == 8'd0) || (rd_entry.scope == item_q.scope));
  assign sts_o.last     = ((idx_ext + CNT_W'(1)) == count_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hdl/ipacl_ctrl.sv =====
`default_nettype none

module ipacl_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire ipacl_pkg::sts_t sts_i,
  output ipacl_pkg::cmd_t      cmd_o
);
  import ipacl_pkg::*;

  state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.kind == KIND_TEST && !sts_i.empty) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_SCAN: begin
        if (sts_i.match || sts_i.last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        case (sts_i.kind)
          KIND_ADD:   cmd_o.exec_add   = 1'b1;
          KIND_CLEAR: cmd_o.exec_clear = 1'b1;
          KIND_TEST:  cmd_o.rd_first   = !sts_i.empty;
          default:    cmd_o            = '0;
        endcase
      end
      ST_SCAN: begin
        cmd_o.hit     = sts_i.match;
        cmd_o.rd_next = !sts_i.match && !sts_i.last;
      end
      ST_FIN: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ipv6_prefix_acl_match.sv =====
// ipv6 prefix access list with admission test
// input stream s_axis: tuser carries the kind (add, test, clear), tdata the
// address, mask, negate flag and scope of one item
// output stream m_axis: one result per item with the verdict, the entry
// count after the item and the table-full error flag
// entries are kept in a single-port-read ram and compared one per cycle
// add, clear and unused kinds: after the accepting edge the item passes the
// execute step and then the final step, which loads the result register
// a test also scans the entries between those steps, up to the first match
// or through all valid entries; a test on an empty table skips the scan
// the next item is accepted the cycle after the result is loaded
// the single ram read port and the one-entry-per-cycle compare set its length
// reset empties the table at once; stored entries are not cleared
// a stalled receiver holds the result in the output register; the block
// then waits in its final step and takes no new item until the result
// register frees up
`default_nettype none

`include "ipv6_prefix_acl_match_assert.svh"

module ipv6_prefix_acl_match #(
  parameter int unsigned ENTRIES = ipacl_pkg::DEF_ENTRIES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // addr_hi, addr_lo, mask_hi, mask_lo, negate, scope_id, zero pad
  input  wire logic [ipacl_pkg::IN_W-1:0]   s_axis_tdata,
  // kind
  input  wire logic [ipacl_pkg::USER_W-1:0] s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // permitted, entry_count, error, zero pad
  output logic [ipacl_pkg::OUT_W-1:0]       m_axis_tdata
);
  import ipacl_pkg::*;

  localparam logic [4:0] FULL_CNT = 5'(ENTRIES);

  cmd_t cmd;
  sts_t sts;

  ipacl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ipacl_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  `ACL_ASSERT(a_one_item_at_a_time,
              s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
              "item accepted while busy")
  `ACL_ASSERT_ALWAYS(a_no_result_overwrite,
                     cmd.finish |-> (!m_axis_tvalid || m_axis_tready),
                     "result overwritten")
  `ACL_ASSERT(a_error_only_when_full,
              m_axis_tvalid && m_axis_tdata[6] |-> m_axis_tdata[5:1] == FULL_CNT,
              "error without full table")

endmodule

`default_nettype wire
